// ===== sv/bfu_pkg.sv =====
`default_nettype none
package bfu_pkg;

  typedef enum logic [1:0] {
    CFG_SRC_WIDTH  = 2'd0,
    CFG_SRC_HEIGHT = 2'd1,
    CFG_DST_WIDTH  = 2'd2,
    CFG_DST_HEIGHT = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    CLAMP_LOW,
    CLAMP_HIGH,
    CLAMP_MID
  } clamp_t;

  localparam logic [9:0]  SRC_WIDTH_RST  = 10'd320;
  localparam logic [9:0]  SRC_HEIGHT_RST = 10'd240;
  localparam logic [11:0] DST_WIDTH_RST  = 12'd640;
  localparam logic [11:0] DST_HEIGHT_RST = 12'd480;
  localparam int          MIN_SIZE       = 8;

  // word carried down the map/divide pipe next to the divider state
  typedef struct packed {
    logic        kind;
    logic [8:0]  col;
    logic [8:0]  row;
    logic [23:0] pix;
    clamp_t      cx;
    clamp_t      cy;
  } side_t;

  // per channel (a*(256-w) + b*w + 128) >> 8
  function automatic logic [23:0] bfu_blend(input logic [23:0] a, input logic [23:0] b,
                                            input logic [7:0] w);
    logic [8:0]  inv;
    logic [16:0] acc;
    logic [23:0] r;
    inv = 9'd256 - {1'b0, w};
    r = '0;
    for (int c = 0; c < 3; c++) begin
      acc = 17'(a[8*c +: 8]) * 17'(inv) + 17'(b[8*c +: 8]) * 17'(w) + 17'd128;
      r[8*c +: 8] = acc[15:8];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== sv/bfu_ram.sv =====
`default_nettype none
module bfu_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== sv/bilinear_frame_upscaler.sv =====
`default_nettype none
// Bilinear frame upscaler. Source pixels (kind 0) are written into a frame store
// split into four banks by row and column parity, so the four neighbors of any
// sample sit in different banks and are fetched in the same cycle. A sample
// request (kind 1) maps each destination axis center-aligned onto the source
// frame, divides exactly with a one-bit-per-stage restoring divider, reads the
// four neighbors and blends horizontally, then vertically. Throughput is one word
// per clock while the output is not stalled, stores and samples mixed freely;
// the divider depth dominates the pipe. Stores are committed at the same pipe
// stage where samples read, so request order is kept. A stalled output freezes
// the whole pipe. Config registers may only be written while the pipe is empty;
// sizes outside their legal ranges are saturated.
module bilinear_frame_upscaler #(
  parameter int MAX_SRC_WIDTH  = 512,
  parameter int MAX_SRC_HEIGHT = 512,
  parameter int MAX_DST_WIDTH  = 2048,
  parameter int MAX_DST_HEIGHT = 2048
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_kind,
  input  wire logic [8:0]  in_src_col,
  input  wire logic [8:0]  in_src_row,
  input  wire logic [23:0] in_pixel_rgb,
  input  wire logic [10:0] in_dst_col,
  input  wire logic [10:0] in_dst_row,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [23:0]      out_rgb,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [11:0] cfg_data
);
  import bfu_pkg::*;

  localparam int CWB  = $clog2(MAX_SRC_WIDTH);
  localparam int RWB  = $clog2(MAX_SRC_HEIGHT);
  localparam int AW   = (CWB > RWB) ? CWB : RWB;          // source index bits
  localparam int SZW  = AW + 1;                           // source size
  localparam int DXB  = $clog2(MAX_DST_WIDTH);
  localparam int DYB  = $clog2(MAX_DST_HEIGHT);
  localparam int DZW  = ((DXB > DYB) ? DXB : DYB) + 1;    // destination size
  localparam int DB   = DZW + 2;                          // divisor 4*dst
  localparam int QB   = AW + 8;                           // index.weight quotient
  localparam int WW   = DB + QB;                          // divider remainder
  localparam int NMW  = 12 + SZW + 1;                     // signed numerator
  localparam int TW   = AW + DZW + 1;                     // (src-1)*2*dst
  localparam int BAW  = 2 * AW - 2;                       // bank address
  localparam int BDEP = 1 << BAW;
  localparam int LW   = 14;

  // ---------------- configuration ----------------
  logic [9:0]  src_width_r, src_height_r;
  logic [11:0] dst_width_r, dst_height_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= SRC_WIDTH_RST;
      src_height_r <= SRC_HEIGHT_RST;
      dst_width_r  <= DST_WIDTH_RST;
      dst_height_r <= DST_HEIGHT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SRC_WIDTH:  src_width_r  <= cfg_data[9:0];
        CFG_SRC_HEIGHT: src_height_r <= cfg_data[9:0];
        CFG_DST_WIDTH:  dst_width_r  <= cfg_data;
        CFG_DST_HEIGHT: dst_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  function automatic logic [LW-1:0] sat(input logic [LW-1:0] v, input logic [LW-1:0] hi);
    logic [LW-1:0] r;
    r = v;
    if (v < LW'(MIN_SIZE)) r = LW'(MIN_SIZE);
    else if (v > hi) r = hi;
    return r;
  endfunction

  logic [SZW-1:0] sw, sh;
  logic [DZW-1:0] dw, dh;
  logic [WW-1:0]  div_x, div_y;

  assign sw = SZW'(sat(LW'(src_width_r),  LW'(MAX_SRC_WIDTH)));
  assign sh = SZW'(sat(LW'(src_height_r), LW'(MAX_SRC_HEIGHT)));
  assign dw = DZW'(sat(LW'(dst_width_r),  LW'(MAX_DST_WIDTH)));
  assign dh = DZW'(sat(LW'(dst_height_r), LW'(MAX_DST_HEIGHT)));
  assign div_x = WW'(dw) << 2;
  assign div_y = WW'(dh) << 2;

  // clamp bounds depend on config only
  logic [TW-1:0] top_x_r, top_y_r;
  always_ff @(posedge clk) begin
    top_x_r <= TW'(sw - SZW'(1)) * TW'({dw, 1'b0});
    top_y_r <= TW'(sh - SZW'(1)) * TW'({dh, 1'b0});
  end

  // ---------------- pipe control ----------------
  logic en;
  logic out_valid_r;
  logic [23:0] out_rgb_r;

  assign en        = !(out_valid_r && out_stall);
  assign in_stall  = !en;
  assign out_valid = out_valid_r;
  assign out_rgb   = out_rgb_r;

  // ---------------- stage 1: numerators ----------------
  logic                  s1_v_r, s1_kind_r;
  logic [8:0]            s1_col_r, s1_row_r;
  logic [23:0]           s1_pix_r;
  logic signed [NMW-1:0] numx_r, numy_r, numx_nxt, numy_nxt;
  logic [NMW-2:0]        prodx, prody;

  always_comb begin
    prodx    = (NMW-1)'({in_dst_col, 1'b1}) * (NMW-1)'(sw);
    prody    = (NMW-1)'({in_dst_row, 1'b1}) * (NMW-1)'(sh);
    numx_nxt = $signed({1'b0, prodx}) - $signed(NMW'(dw));
    numy_nxt = $signed({1'b0, prody}) - $signed(NMW'(dh));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_kind_r <= in_kind;
      s1_col_r  <= in_src_col;
      s1_row_r  <= in_src_row;
      s1_pix_r  <= in_pixel_rgb;
      numx_r    <= numx_nxt;
      numy_r    <= numy_nxt;
    end
  end

  // ---------------- stage 2: clamp, divider load ----------------
  logic          dv_r   [QB+1];
  side_t         side_r [QB+1];
  logic [WW-1:0] rx_r   [QB+1];
  logic [WW-1:0] ry_r   [QB+1];
  logic [QB-1:0] qx_r   [QB+1];
  logic [QB-1:0] qy_r   [QB+1];

  side_t         side_nxt;
  logic [WW-1:0] nx_ld, ny_ld;

  always_comb begin
    side_nxt      = '0;
    side_nxt.kind = s1_kind_r;
    side_nxt.col  = s1_col_r;
    side_nxt.row  = s1_row_r;
    side_nxt.pix  = s1_pix_r;
    if (numx_r[NMW-1] || numx_r == '0) begin
      side_nxt.cx = CLAMP_LOW;
    end else if ({{TW{1'b0}}, numx_r[NMW-2:0]} >= {{(NMW-1){1'b0}}, top_x_r}) begin
      side_nxt.cx = CLAMP_HIGH;
    end else begin
      side_nxt.cx = CLAMP_MID;
    end
    if (numy_r[NMW-1] || numy_r == '0) begin
      side_nxt.cy = CLAMP_LOW;
    end else if ({{TW{1'b0}}, numy_r[NMW-2:0]} >= {{(NMW-1){1'b0}}, top_y_r}) begin
      side_nxt.cy = CLAMP_HIGH;
    end else begin
      side_nxt.cy = CLAMP_MID;
    end
    // (n*512 + den) / (2*den): index in the high bits, rounded weight below
    nx_ld = (WW'(numx_r[NMW-2:0]) << 9) + (WW'(dw) << 1);
    ny_ld = (WW'(numy_r[NMW-2:0]) << 9) + (WW'(dh) << 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r[0] <= 1'b0;
    end else if (en) begin
      dv_r[0] <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_nxt;
      rx_r[0]   <= nx_ld;
      ry_r[0]   <= ny_ld;
      qx_r[0]   <= '0;
      qy_r[0]   <= '0;
    end
  end

  // ---------------- restoring divider, one quotient bit per stage ----------------
  for (genvar s = 0; s < QB; s++) begin : g_div
    localparam int K = QB - 1 - s;
    logic [WW-1:0] dxs, dys;
    logic          gx, gy;
    assign dxs = div_x << K;
    assign dys = div_y << K;
    assign gx  = rx_r[s] >= dxs;
    assign gy  = ry_r[s] >= dys;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[s+1] <= 1'b0;
      end else if (en) begin
        dv_r[s+1] <= dv_r[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[s+1] <= side_r[s];
        rx_r[s+1]   <= gx ? rx_r[s] - dxs : rx_r[s];
        ry_r[s+1]   <= gy ? ry_r[s] - dys : ry_r[s];
        qx_r[s+1]   <= qx_r[s] | (QB'(gx) << K);
        qy_r[s+1]   <= qy_r[s] | (QB'(gy) << K);
      end
    end
  end

  // ---------------- taps, store write and bank read ----------------
  side_t         sd;
  logic [QB-1:0] tx, ty;
  logic [AW-1:0] xlo, xhi, ylo, yhi;
  logic [AW-1:0] wcol, wrow;
  logic          w_inb, w_en;
  logic [BAW-1:0] w_addr;
  logic [1:0]     w_bank;
  logic [BAW-1:0] r_addr [4];
  logic [23:0]    rd     [4];

  assign sd = side_r[QB];

  always_comb begin
    unique case (sd.cx)
      CLAMP_LOW:  tx = '0;
      CLAMP_HIGH: tx = {AW'(sw - SZW'(1)), 8'h00};
      default:    tx = qx_r[QB];
    endcase
    unique case (sd.cy)
      CLAMP_LOW:  ty = '0;
      CLAMP_HIGH: ty = {AW'(sh - SZW'(1)), 8'h00};
      default:    ty = qy_r[QB];
    endcase
    xlo = tx[QB-1:8];
    ylo = ty[QB-1:8];
    xhi = (SZW'(xlo) + SZW'(1) < sw) ? xlo + AW'(1) : xlo;
    yhi = (SZW'(ylo) + SZW'(1) < sh) ? ylo + AW'(1) : ylo;
    for (int b = 0; b < 4; b++) begin
      r_addr[b] = {((ylo[0] == b[1]) ? ylo[AW-1:1] : yhi[AW-1:1]),
                   ((xlo[0] == b[0]) ? xlo[AW-1:1] : xhi[AW-1:1])};
    end
    wcol   = AW'(sd.col);
    wrow   = AW'(sd.row);
    w_inb  = (LW'(sd.col) < LW'(MAX_SRC_WIDTH)) && (LW'(sd.row) < LW'(MAX_SRC_HEIGHT));
    w_en   = en && dv_r[QB] && !sd.kind && w_inb;
    w_addr = {wrow[AW-1:1], wcol[AW-1:1]};
    w_bank = {wrow[0], wcol[0]};
  end

  for (genvar b = 0; b < 4; b++) begin : g_bank
    bfu_ram #(
      .WIDTH (24),
      .DEPTH (BDEP)
    ) u_bank (
      .clk   (clk),
      .we    (w_en && (w_bank == 2'(b))),
      .waddr (w_addr),
      .wdata (sd.pix),
      .re    (en),
      .raddr (r_addr[b]),
      .rdata (rd[b])
    );
  end

  logic       sa_v_r, sa_kind_r;
  logic [7:0] sa_wx_r, sa_wy_r;
  logic       sa_xlo_r, sa_xhi_r, sa_ylo_r, sa_yhi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sa_v_r <= 1'b0;
    end else if (en) begin
      sa_v_r <= dv_r[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sa_kind_r <= sd.kind;
      sa_wx_r   <= tx[7:0];
      sa_wy_r   <= ty[7:0];
      sa_xlo_r  <= xlo[0];
      sa_xhi_r  <= xhi[0];
      sa_ylo_r  <= ylo[0];
      sa_yhi_r  <= yhi[0];
    end
  end

  // ---------------- horizontal blend ----------------
  logic        sb_v_r, sb_kind_r;
  logic [7:0]  sb_wy_r;
  logic [23:0] sb_top_r, sb_bot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sb_v_r <= 1'b0;
    end else if (en) begin
      sb_v_r <= sa_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb_kind_r <= sa_kind_r;
      sb_wy_r   <= sa_wy_r;
      sb_top_r  <= bfu_blend(rd[{sa_ylo_r, sa_xlo_r}], rd[{sa_ylo_r, sa_xhi_r}], sa_wx_r);
      sb_bot_r  <= bfu_blend(rd[{sa_yhi_r, sa_xlo_r}], rd[{sa_yhi_r, sa_xhi_r}], sa_wx_r);
    end
  end

  // ---------------- vertical blend, output word ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= sb_v_r && sb_kind_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rgb_r <= bfu_blend(sb_top_r, sb_bot_r, sb_wy_r);
    end
  end

endmodule
`default_nettype wire
